FILE: rtl/mssd_pkg.sv
// Package for the multiplexed seven-segment display driver.
// Holds opcodes, register indexes, reset values and the character-to-segment map.
// No dependencies.
package mssd_pkg;

  localparam int NUM_DIGITS_DEFAULT = 3;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int STEP_W      = 5;
  localparam int ENABLE_W    = 3;

  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_BEGIN = 3'd1;
  localparam logic [2:0] OP_CHAR  = 3'd2;
  localparam logic [2:0] OP_SHOW  = 3'd3;
  localparam logic [2:0] OP_BLINK = 3'd4;

  localparam logic [CFG_INDEX_W-1:0] REG_SHOW_TIME       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BLINK_FIRST_ON  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BLINK_OFF       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BLINK_SECOND_ON = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SCAN_STEP       = 3'd4;

  localparam logic [15:0]       SHOW_TIME_RESET       = 16'd3000;
  localparam logic [15:0]       BLINK_FIRST_ON_RESET  = 16'd200;
  localparam logic [15:0]       BLINK_OFF_RESET       = 16'd400;
  localparam logic [15:0]       BLINK_SECOND_ON_RESET = 16'd600;
  localparam logic [STEP_W-1:0] SCAN_STEP_RESET       = 5'd5;

  localparam logic [1:0] TAIL_OPEN = 2'd0;
  localparam logic [1:0] TAIL_FULL = 2'd1;
  localparam logic [1:0] TAIL_DONE = 2'd2;

  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [7:0] DP_BIT           = 8'h80;
  localparam logic [7:0] FALLBACK_PATTERN = 8'h49;

  typedef logic [7:0] seg_t;

  localparam seg_t DIGIT_TABLE [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  function automatic seg_t seg_of_char(input logic [7:0] c);
    seg_t s;
    s = FALLBACK_PATTERN;
    if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
      s = DIGIT_TABLE[c[3:0]];
    end else if (c == CHAR_SPACE) begin
      s = '0;
    end
    return s;
  endfunction

endpackage

FILE: rtl/multiplexed_seven_segment_driver_top.sv
// Multiplexed seven-segment display driver, top level.
// Depends on mssd_pkg.
//
//   channel   signals                               payload
//   item      item_valid / item_stall               opcode, char_code
//   result    result_valid / result_stall           segments, digit_enables, lit
//   config    cfg_write, cfg_index, cfg_data        one register per write
//
// One word per cycle while item_stall is low; each word's result is presented after it passes
// the input register and then the state update that loads the display latches.
// Reset: counters zero, digit store blank, display latches off, lit high.
// A stalled result holds the latches; item_stall rises only while the input
// register is full and the result is stalled.
module multiplexed_seven_segment_driver_top import mssd_pkg::*; #(
  parameter int NUM_DIGITS = NUM_DIGITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  logic [2:0]             opcode,
  input  logic [7:0]             char_code,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [7:0]             segments,
  output logic [ENABLE_W-1:0]    digit_enables,
  output logic                   lit,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int DW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int PW = $clog2(NUM_DIGITS + 1);
  localparam int LW = STEP_W + DW + 1;

  logic [15:0]       show_time;
  logic [15:0]       blink_first_on_end;
  logic [15:0]       blink_off_end;
  logic [15:0]       blink_second_on_end;
  logic [STEP_W-1:0] scan_step;

  logic       s1_valid;
  logic [2:0] s1_opcode;
  logic [7:0] s1_char;

  logic [15:0]   show_count;
  logic [15:0]   blink_count;
  logic [7:0]    scan_count;
  logic [DW-1:0] current_digit;
  logic          refresh_pending;
  logic          dark_flag;
  seg_t          digit_patterns [NUM_DIGITS];
  logic [PW-1:0] write_position;
  logic [1:0]    tail_state;
  logic [7:0]    segment_latch;
  logic [ENABLE_W-1:0] enable_latch;

  logic                out_free;
  logic                process;
  logic [15:0]         show_next;
  logic [15:0]         blink_next;
  logic [7:0]          scan_inc;
  logic                on;
  logic [LW-1:0]       limit;
  logic                advance;
  logic                wrap;
  logic [DW-1:0]       digit_next;
  logic [ENABLE_W-1:0] enable_next;
  seg_t                char_pattern;

  assign out_free   = !result_valid || !result_stall;
  assign item_stall = s1_valid && !out_free;
  assign process    = s1_valid && out_free;

  assign segments      = segment_latch;
  assign digit_enables = enable_latch;
  assign lit           = !dark_flag;

  always_comb begin
    show_next  = show_count + 16'(show_count != 16'hFFFF);
    blink_next = blink_count + 16'(blink_count != 16'hFFFF);
    scan_inc   = scan_count + 8'(scan_count != 8'hFF);
    on = (show_next < show_time) || (blink_next < blink_first_on_end) ||
         ((blink_next > blink_off_end) && (blink_next < blink_second_on_end));
    limit   = LW'(scan_step) * (LW'(current_digit) + LW'(1));
    advance = 16'(scan_inc) > 16'(limit);
    wrap    = advance && (int'(current_digit) >= NUM_DIGITS - 1);
    if (!advance) begin
      digit_next = current_digit;
    end else if (wrap) begin
      digit_next = '0;
    end else begin
      digit_next = current_digit + DW'(1);
    end
    for (int i = 0; i < ENABLE_W; i++) begin
      enable_next[i] = (int'(digit_next) == i);
    end
    char_pattern = seg_of_char(s1_char);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      show_time           <= SHOW_TIME_RESET;
      blink_first_on_end  <= BLINK_FIRST_ON_RESET;
      blink_off_end       <= BLINK_OFF_RESET;
      blink_second_on_end <= BLINK_SECOND_ON_RESET;
      scan_step           <= SCAN_STEP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SHOW_TIME:       show_time           <= cfg_data;
        REG_BLINK_FIRST_ON:  blink_first_on_end  <= cfg_data;
        REG_BLINK_OFF:       blink_off_end       <= cfg_data;
        REG_BLINK_SECOND_ON: blink_second_on_end <= cfg_data;
        REG_SCAN_STEP:       scan_step           <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall) begin
      s1_opcode <= opcode;
      s1_char   <= char_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      show_count      <= '0;
      blink_count     <= '0;
      scan_count      <= '0;
      current_digit   <= '0;
      refresh_pending <= 1'b1;
      dark_flag       <= 1'b0;
      segment_latch   <= '0;
      enable_latch    <= '0;
      write_position  <= '0;
      tail_state      <= TAIL_OPEN;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        digit_patterns[i] <= '0;
      end
    end else if (process) begin
      case (s1_opcode)
        OP_TICK: begin
          show_count  <= show_next;
          blink_count <= blink_next;
          scan_count  <= (on && wrap) ? '0 : scan_inc;
          if (on) begin
            current_digit <= digit_next;
            if (refresh_pending || advance) begin
              refresh_pending <= 1'b0;
              segment_latch   <= digit_patterns[digit_next];
              enable_latch    <= enable_next;
            end
            dark_flag <= 1'b0;
          end else if (!dark_flag) begin
            dark_flag     <= 1'b1;
            segment_latch <= '0;
            enable_latch  <= '0;
          end
        end
        OP_BEGIN: begin
          write_position <= '0;
          tail_state     <= TAIL_OPEN;
        end
        OP_CHAR: begin
          if (tail_state == TAIL_FULL) begin
            if (s1_char == CHAR_DOT) begin
              digit_patterns[NUM_DIGITS-1] <= digit_patterns[NUM_DIGITS-1] | DP_BIT;
            end
            tail_state <= TAIL_DONE;
          end else if (tail_state == TAIL_OPEN && int'(write_position) < NUM_DIGITS) begin
            if (s1_char == CHAR_DOT) begin
              for (int i = 0; i < NUM_DIGITS; i++) begin
                if (int'(write_position) == i + 1) begin
                  digit_patterns[i] <= digit_patterns[i] | DP_BIT;
                end
              end
            end else begin
              for (int i = 0; i < NUM_DIGITS; i++) begin
                if (int'(write_position) == i) begin
                  digit_patterns[i] <= char_pattern;
                end
              end
              write_position <= write_position + PW'(1);
              if (int'(write_position) + 1 >= NUM_DIGITS) begin
                tail_state <= TAIL_FULL;
              end
            end
          end
        end
        OP_SHOW:  show_count  <= '0;
        OP_BLINK: blink_count <= '0;
        default: ;
      endcase
    end
  end

endmodule
